// ===== src/timestamp_nearest_match_queues_defines.svh =====
// Assertion macros shared by the timestamp match queue checkers
`ifndef TIMESTAMP_NEAREST_MATCH_QUEUES_DEFINES_SVH
`define TIMESTAMP_NEAREST_MATCH_QUEUES_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TNMQ_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnmq assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define TNMQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnmq assertion failed");

`endif

// ===== src/tnmq_pkg.sv =====
// Shared constants and types for the timestamp match queues
`default_nettype none

package tnmq_pkg;

    localparam int STAMP_W = 63;
    localparam int TAG_W = 16;
    localparam int DELTA_W = 16;
    localparam int AGE_W = 36;
    localparam int LIMIT_W = 36;
    localparam int NS_PER_MS_W = 20;
    localparam int ENTRY_W = STAMP_W + TAG_W;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [NS_PER_MS_W-1:0] NS_PER_MS = 20'd1000000;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 36'd100000000;
    localparam logic [AGE_W-1:0] MAX_AGE_RST = 36'd1000000000;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = AGE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELTA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 1'b1;

    localparam logic [1:0] FUNC_PUSH_DET = 2'd0;
    localparam logic [1:0] FUNC_PUSH_REF = 2'd1;
    localparam logic [1:0] FUNC_SYNC = 2'd2;
    localparam logic [1:0] FUNC_SET_CAM = 2'd3;

    localparam logic [1:0] STAT_ACCEPTED = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_MATCH = 2'd2;
    localparam logic [1:0] STAT_NO_MATCH = 2'd3;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

endpackage

`default_nettype wire

// ===== src/tnmq_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none

module tnmq_ram #(
    parameter int WIDTH = tnmq_pkg::ENTRY_W,
    parameter int DEPTH = tnmq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/timestamp_nearest_match_queues.sv =====
// Top level: detection and reference timestamp queues with nearest-match sync
//
// Usage: one request channel (in_valid/in_ready) carries func, event_stamp,
// entry_tag and camera_on; one result channel (out_valid/out_ready) returns
// exactly one result per request. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); index 0 is max_delta_ms, index 1 max_age_ns.
// Pushes, camera mode requests and sync ticks rejected up front go from the
// execute state straight to the output register. A full sync tick prunes
// stale detections, then stale references, one entry at a time through the
// single shared age check, then scans the reference queue: the queue RAM read
// port and the gap unit walk one entry per cycle. A tick that
// prunes a queue empty skips the scan. in_ready is high only while the
// sequencer is idle, so no request is taken while another is in progress.
// A finished result sits in the output register; the next request is taken
// meanwhile and its result waits until out_ready frees that register.
// Reset empties both queues, turns camera mode off and restores the
// configuration defaults (100 ms, 1 s). Queue RAM contents are not cleared.
`default_nettype none

module timestamp_nearest_match_queues #(
    parameter int QUEUE_DEPTH = tnmq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [tnmq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tnmq_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            func,
    input  wire logic [tnmq_pkg::STAMP_W-1:0]          event_stamp,
    input  wire logic [tnmq_pkg::TAG_W-1:0]            entry_tag,
    input  wire logic                                  camera_on,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [1:0]                                 status,
    output logic [tnmq_pkg::TAG_W-1:0]                 detected_tag,
    output logic [tnmq_pkg::TAG_W-1:0]                 reference_tag,
    output logic [tnmq_pkg::STAMP_W-1:0]               detected_time,
    output logic [tnmq_pkg::STAMP_W-1:0]               reference_time,
    output logic [tnmq_pkg::STAMP_W-1:0]               match_gap_ns,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]           detection_count,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]           reference_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = tnmq_pkg::STAMP_W;
    localparam int TW = tnmq_pkg::TAG_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_DPR_RD = 4'd2;
    localparam logic [3:0] S_DPR_CHK = 4'd3;
    localparam logic [3:0] S_RPR_RD = 4'd4;
    localparam logic [3:0] S_RPR_CHK = 4'd5;
    localparam logic [3:0] S_SCAN = 4'd6;
    localparam logic [3:0] S_MATCH = 4'd7;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            s = s - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // control state
    logic [3:0]                   state_reg, state_next;
    logic                         camera_mode_reg, camera_mode_next;
    logic [PTR_W-1:0]             det_head_reg, det_head_next;
    logic [CNT_W-1:0]             det_fill_reg, det_fill_next;
    logic [PTR_W-1:0]             ref_head_reg, ref_head_next;
    logic [CNT_W-1:0]             ref_fill_reg, ref_fill_next;
    logic [tnmq_pkg::LIMIT_W-1:0] limit_reg;
    logic [tnmq_pkg::AGE_W-1:0]   max_age_reg;
    logic [CNT_W-1:0]             issue_idx_reg, issue_idx_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         gap_vld_reg;
    logic                         out_valid_reg, out_valid_next;

    // payload
    logic [1:0]                   func_reg;
    logic [SW-1:0]                stamp_reg;
    logic [TW-1:0]                tag_reg;
    logic                         cam_reg;
    logic [SW-1:0]                det_last_stamp_reg, det_last_stamp_next;
    logic [TW-1:0]                det_last_tag_reg, det_last_tag_next;
    logic [SW-1:0]                ref_last_stamp_reg, ref_last_stamp_next;
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]             gap_idx_reg;
    logic [SW-1:0]                gap_reg;
    tnmq_pkg::entry_t             gap_entry_reg;
    logic [SW-1:0]                best_gap_reg, best_gap_next;
    logic [CNT_W-1:0]             best_idx_reg, best_idx_next;
    tnmq_pkg::entry_t             best_entry_reg, best_entry_next;
    logic [1:0]                   status_reg, status_next;
    logic [TW-1:0]                dtag_reg, dtag_next;
    logic [TW-1:0]                rtag_reg, rtag_next;
    logic [SW-1:0]                dtime_reg, dtime_next;
    logic [SW-1:0]                rtime_reg, rtime_next;
    logic [SW-1:0]                mgap_reg, mgap_next;
    logic [CNT_W-1:0]             dcnt_reg, dcnt_next;
    logic [CNT_W-1:0]             rcnt_reg, rcnt_next;

    // memories
    logic                         det_we, ref_we;
    logic [PTR_W-1:0]             det_waddr, ref_waddr;
    logic [PTR_W-1:0]             det_raddr, ref_raddr;
    tnmq_pkg::entry_t             wr_entry;
    tnmq_pkg::entry_t             det_rdata, ref_rdata;

    // shared prune and gap units
    tnmq_pkg::entry_t             prune_entry;
    logic [SW-1:0]                age_diff;
    logic                         stale;
    logic [SW:0]                  gap_up, gap_dn;
    logic [SW-1:0]                gap_calc;
    logic                         out_free;
    logic                         in_fire;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign wr_entry = '{tag: tag_reg, stamp: stamp_reg};

    tnmq_ram #(
        .WIDTH(tnmq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_det_ram (
        .clk  (clk),
        .we   (det_we),
        .waddr(det_waddr),
        .wdata(wr_entry),
        .raddr(det_raddr),
        .rdata(det_rdata)
    );

    tnmq_ram #(
        .WIDTH(tnmq_pkg::ENTRY_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ref_ram (
        .clk  (clk),
        .we   (ref_we),
        .waddr(ref_waddr),
        .wdata(wr_entry),
        .raddr(ref_raddr),
        .rdata(ref_rdata)
    );

    // age check against the tick time, shared by both queues
    always_comb
    begin
        prune_entry = (state_reg == S_DPR_CHK) ? det_rdata : ref_rdata;
        age_diff = stamp_reg - prune_entry.stamp;
        stale = (stamp_reg > prune_entry.stamp) &&
                (age_diff > SW'(max_age_reg));
    end

    // absolute stamp distance to the newest detection
    always_comb
    begin
        gap_up = {1'b0, ref_rdata.stamp} - {1'b0, det_last_stamp_reg};
        gap_dn = {1'b0, det_last_stamp_reg} - {1'b0, ref_rdata.stamp};
        gap_calc = gap_up[SW] ? gap_dn[SW-1:0] : gap_up[SW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        camera_mode_next = camera_mode_reg;
        det_head_next = det_head_reg;
        det_fill_next = det_fill_reg;
        ref_head_next = ref_head_reg;
        ref_fill_next = ref_fill_reg;
        det_last_stamp_next = det_last_stamp_reg;
        det_last_tag_next = det_last_tag_reg;
        ref_last_stamp_next = ref_last_stamp_reg;
        issue_idx_next = issue_idx_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        best_gap_next = best_gap_reg;
        best_idx_next = best_idx_reg;
        best_entry_next = best_entry_reg;
        det_we = 1'b0;
        ref_we = 1'b0;
        det_waddr = det_head_reg;
        ref_waddr = ref_head_reg;
        det_raddr = det_head_reg;
        ref_raddr = ref_head_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next = status_reg;
        dtag_next = dtag_reg;
        rtag_next = rtag_reg;
        dtime_next = dtime_reg;
        rtime_next = rtime_reg;
        mgap_next = mgap_reg;
        dcnt_next = dcnt_reg;
        rcnt_next = rcnt_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (func_reg == tnmq_pkg::FUNC_SYNC && camera_mode_reg &&
                    det_fill_reg != '0 && ref_fill_reg != '0)
                begin
                    state_next = S_DPR_RD;
                end
                else if (out_free)
                begin
                    status_next = tnmq_pkg::STAT_ACCEPTED;
                    case (func_reg)
                        tnmq_pkg::FUNC_PUSH_DET:
                        begin
                            if (camera_mode_reg && (det_fill_reg == '0 ||
                                stamp_reg > det_last_stamp_reg))
                            begin
                                det_we = 1'b1;
                                det_last_stamp_next = stamp_reg;
                                det_last_tag_next = tag_reg;
                                if (det_fill_reg == FULL)
                                begin
                                    det_waddr = det_head_reg;
                                    det_head_next = wrap_add(det_head_reg, ONE);
                                end
                                else
                                begin
                                    det_waddr = wrap_add(det_head_reg, det_fill_reg);
                                    det_fill_next = det_fill_reg + ONE;
                                end
                            end
                            else
                            begin
                                status_next = tnmq_pkg::STAT_DROPPED;
                            end
                        end
                        tnmq_pkg::FUNC_PUSH_REF:
                        begin
                            if (ref_fill_reg == '0 || stamp_reg > ref_last_stamp_reg)
                            begin
                                ref_we = 1'b1;
                                ref_last_stamp_next = stamp_reg;
                                if (ref_fill_reg == FULL)
                                begin
                                    ref_waddr = ref_head_reg;
                                    ref_head_next = wrap_add(ref_head_reg, ONE);
                                end
                                else
                                begin
                                    ref_waddr = wrap_add(ref_head_reg, ref_fill_reg);
                                    ref_fill_next = ref_fill_reg + ONE;
                                end
                            end
                            else
                            begin
                                status_next = tnmq_pkg::STAT_DROPPED;
                            end
                        end
                        tnmq_pkg::FUNC_SYNC:
                        begin
                            status_next = tnmq_pkg::STAT_NO_MATCH;
                        end
                        default:
                        begin
                            camera_mode_next = cam_reg;
                            if (!cam_reg)
                            begin
                                det_head_next = '0;
                                det_fill_next = '0;
                                ref_head_next = '0;
                                ref_fill_next = '0;
                            end
                        end
                    endcase
                    out_valid_next = 1'b1;
                    dtag_next = '0;
                    rtag_next = '0;
                    dtime_next = '0;
                    rtime_next = '0;
                    mgap_next = '0;
                    dcnt_next = det_fill_next;
                    rcnt_next = ref_fill_next;
                    state_next = S_IDLE;
                end
            end

            S_DPR_RD:
            begin
                state_next = S_DPR_CHK;
            end

            S_DPR_CHK:
            begin
                if (stale)
                begin
                    det_head_next = wrap_add(det_head_reg, ONE);
                    det_fill_next = det_fill_reg - ONE;
                    state_next = (det_fill_reg == ONE) ? S_RPR_RD : S_DPR_RD;
                end
                else
                begin
                    state_next = S_RPR_RD;
                end
            end

            S_RPR_RD:
            begin
                state_next = S_RPR_CHK;
            end

            S_RPR_CHK:
            begin
                issue_idx_next = '0;
                if (stale)
                begin
                    ref_head_next = wrap_add(ref_head_reg, ONE);
                    ref_fill_next = ref_fill_reg - ONE;
                    state_next = (ref_fill_reg == ONE) ? S_MATCH : S_RPR_RD;
                end
                else
                begin
                    state_next = (det_fill_reg != '0) ? S_SCAN : S_MATCH;
                end
            end

            S_SCAN:
            begin
                // issue one read a cycle; compare once the RAM output and gap registers hold it
                if (issue_idx_reg < ref_fill_reg)
                begin
                    ref_raddr = wrap_add(ref_head_reg, issue_idx_reg);
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_idx_reg;
                    issue_idx_next = issue_idx_reg + ONE;
                end
                if (gap_vld_reg)
                begin
                    if (gap_idx_reg == '0 || gap_reg < best_gap_reg)
                    begin
                        best_gap_next = gap_reg;
                        best_idx_next = gap_idx_reg;
                        best_entry_next = gap_entry_reg;
                    end
                    if (gap_idx_reg == ref_fill_reg - ONE)
                    begin
                        state_next = S_MATCH;
                    end
                end
            end

            S_MATCH:
            begin
                if (out_free)
                begin
                    status_next = tnmq_pkg::STAT_NO_MATCH;
                    dtag_next = '0;
                    rtag_next = '0;
                    dtime_next = '0;
                    rtime_next = '0;
                    mgap_next = '0;
                    if (det_fill_reg != '0 && ref_fill_reg != '0 &&
                        best_gap_reg <= SW'(limit_reg))
                    begin
                        status_next = tnmq_pkg::STAT_MATCH;
                        dtag_next = det_last_tag_reg;
                        rtag_next = best_entry_reg.tag;
                        dtime_next = det_last_stamp_reg;
                        rtime_next = best_entry_reg.stamp;
                        mgap_next = best_gap_reg;
                        ref_head_next = wrap_add(ref_head_reg, best_idx_reg + ONE);
                        ref_fill_next = ref_fill_reg - best_idx_reg - ONE;
                    end
                    out_valid_next = 1'b1;
                    dcnt_next = det_fill_next;
                    rcnt_next = ref_fill_next;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            camera_mode_reg <= 1'b0;
            det_head_reg <= '0;
            det_fill_reg <= '0;
            ref_head_reg <= '0;
            ref_fill_reg <= '0;
            issue_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            gap_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg <= tnmq_pkg::LIMIT_RST;
            max_age_reg <= tnmq_pkg::MAX_AGE_RST;
        end
        else
        begin
            state_reg <= state_next;
            camera_mode_reg <= camera_mode_next;
            det_head_reg <= det_head_next;
            det_fill_reg <= det_fill_next;
            ref_head_reg <= ref_head_next;
            ref_fill_reg <= ref_fill_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg <= rd_vld_next;
            gap_vld_reg <= rd_vld_reg;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tnmq_pkg::CFG_MAX_DELTA:
                    begin
                        limit_reg <= tnmq_pkg::LIMIT_W'(cfg_data[tnmq_pkg::DELTA_W-1:0]) *
                                     tnmq_pkg::LIMIT_W'(tnmq_pkg::NS_PER_MS);
                    end
                    tnmq_pkg::CFG_MAX_AGE:
                    begin
                        max_age_reg <= cfg_data;
                    end
                    default:
                    begin
                        max_age_reg <= max_age_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func;
            stamp_reg <= event_stamp;
            tag_reg <= entry_tag;
            cam_reg <= camera_on;
        end
        det_last_stamp_reg <= det_last_stamp_next;
        det_last_tag_reg <= det_last_tag_next;
        ref_last_stamp_reg <= ref_last_stamp_next;
        rd_idx_reg <= rd_idx_next;
        gap_idx_reg <= rd_idx_reg;
        gap_reg <= gap_calc;
        gap_entry_reg <= ref_rdata;
        best_gap_reg <= best_gap_next;
        best_idx_reg <= best_idx_next;
        best_entry_reg <= best_entry_next;
        status_reg <= status_next;
        dtag_reg <= dtag_next;
        rtag_reg <= rtag_next;
        dtime_reg <= dtime_next;
        rtime_reg <= rtime_next;
        mgap_reg <= mgap_next;
        dcnt_reg <= dcnt_next;
        rcnt_reg <= rcnt_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign detected_tag = dtag_reg;
    assign reference_tag = rtag_reg;
    assign detected_time = dtime_reg;
    assign reference_time = rtime_reg;
    assign match_gap_ns = mgap_reg;
    assign detection_count = dcnt_reg;
    assign reference_count = rcnt_reg;

endmodule

`default_nettype wire

// ===== src/tnmq_checker.sv =====
// Port-level checker for the timestamp match queues, bound to the top level
`default_nettype none
`include "timestamp_nearest_match_queues_defines.svh"

module tnmq_checker #(
    parameter int QUEUE_DEPTH = tnmq_pkg::QUEUE_DEPTH_DEF
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [1:0]                         status,
    input wire logic [tnmq_pkg::TAG_W-1:0]         detected_tag,
    input wire logic [tnmq_pkg::TAG_W-1:0]         reference_tag,
    input wire logic [tnmq_pkg::STAMP_W-1:0]       detected_time,
    input wire logic [tnmq_pkg::STAMP_W-1:0]       reference_time,
    input wire logic [tnmq_pkg::STAMP_W-1:0]       match_gap_ns,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   detection_count,
    input wire logic [$clog2(QUEUE_DEPTH+1)-1:0]   reference_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // hold a stalled result
    `TNMQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

    // busy after taking a request
    `TNMQ_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)

    `TNMQ_ASSERT_IMM(a_count_bound, out_valid,
        detection_count <= CNT_W'(QUEUE_DEPTH) && reference_count <= CNT_W'(QUEUE_DEPTH))

    `TNMQ_ASSERT_IMM(a_zero_unless_match, out_valid && status != tnmq_pkg::STAT_MATCH,
        detected_tag == '0 && reference_tag == '0 && detected_time == '0 &&
        reference_time == '0 && match_gap_ns == '0)

    `TNMQ_ASSERT_IMM(a_gap_consistent, out_valid && status == tnmq_pkg::STAT_MATCH,
        (detected_time >= reference_time) ? (match_gap_ns == detected_time - reference_time)
                                          : (match_gap_ns == reference_time - detected_time))

endmodule

bind timestamp_nearest_match_queues tnmq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tnmq_checker (.*);

`default_nettype wire
